/* sv/scba_pkg.sv */
// Package with the shared types, codes and constants of the size-class block allocator.
package scba_pkg;

    localparam int FIELD_W    = 40;
    localparam int SIZE_W     = 16;
    localparam int BYTES_W    = 33;
    localparam int STATUS_W   = 2;
    localparam int CLASS_W    = 3;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 64;
    localparam int RAW_CLASS_W = 4;

    localparam logic [BYTES_W-1:0] ARENA_RESET = 33'd33554432;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MEMORY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // Register index is taken from address bit 3 (registers sit 8 bytes apart).
    localparam logic REG_ARENA_BASE  = 1'b0;
    localparam logic REG_ARENA_BYTES = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] req_size;
        logic [FIELD_W-1:0] free_addr;
    } req_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  block_addr;
        logic [STATUS_W-1:0] status;
        logic [CLASS_W-1:0]  size_class;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic pop;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_needed;
    } dp_stat_t;

endpackage

/* sv/size_class_block_allocator.sv */
// Top level of the size-class block allocator: registers, controller and datapath.
//
//  Channel   Direction  Handshake                    Payload
//  request   in         start high while busy low    req    (req_t)
//  result    out        done strobe, one cycle       result (result_t)
//  config    in/out     APB write, pready always 1   pwdata / prdata
//
// A free, a bump allocation or a rejected request goes through the execute
// state to the done strobe; an allocation served from a free stack also passes
// through the pop state, since the stack memory read is registered before the result.
// A new request may be accepted in the cycle in which done is high.
// Reset clears the stack counts and the bump offset at once; the stack memory
// itself is not cleared, because an entry is only read after it was pushed.
// The receiver cannot stall: each result is valid for exactly one cycle.
module size_class_block_allocator
    import scba_pkg::*;
#(
    parameter int STACK_DEPTH  = 256,
    parameter int CLASS_COUNT  = 8,
    parameter int ADDRESS_BITS = 40
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  req_t               req,
    output logic               done,
    output result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Configuration values shared with the datapath. The user must change them only
    // while no transaction is in flight; the block itself does not enforce it.
    logic [FIELD_W-1:0] arena_base;
    logic [BYTES_W-1:0] arena_bytes;

    // The controller tells the datapath when to capture a request, when to
    // execute it and when to finish a stack pop.
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    scba_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .arena_base  (arena_base),
        .arena_bytes (arena_bytes)
    );

    scba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // The datapath rounds the size to its class, checks the class stack and
    // either pops it, pushes onto it, carves a block from the arena or rejects the request.
    scba_dpath #(
        .STACK_DEPTH  (STACK_DEPTH),
        .CLASS_COUNT  (CLASS_COUNT),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req         (req),
        .arena_base  (arena_base),
        .arena_bytes (arena_bytes),
        .stat        (stat),
        .done        (done),
        .result      (result)
    );

endmodule

/* sv/scba_regs.sv */
// APB-style configuration registers for the arena base and size.
module scba_regs
    import scba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,
    output logic [FIELD_W-1:0]   arena_base,
    output logic [BYTES_W-1:0]   arena_bytes
);

    logic [FIELD_W-1:0] arena_base_reg;
    logic [BYTES_W-1:0] arena_bytes_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_base_reg  <= '0;
            arena_bytes_reg <= ARENA_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[3])
                REG_ARENA_BASE:  arena_base_reg  <= pwdata[FIELD_W-1:0];
                REG_ARENA_BYTES: arena_bytes_reg <= pwdata[BYTES_W-1:0];
                default:         arena_base_reg  <= arena_base_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3])
            REG_ARENA_BASE:  prdata = PDATA_W'(arena_base_reg);
            REG_ARENA_BYTES: prdata = PDATA_W'(arena_bytes_reg);
            default:         prdata = '0;
        endcase
    end

    assign arena_base  = arena_base_reg;
    assign arena_bytes = arena_bytes_reg;

endmodule

/* sv/scba_ctrl.sv */
// Controller state machine that sequences each allocator request.
module scba_ctrl
    import scba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  dp_stat_t  stat,
    output logic      busy,
    output ctrl_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign busy     = (state_reg != S_IDLE);
    assign cmd.load = start && !busy;
    assign cmd.exec = (state_reg == S_EXEC);
    assign cmd.pop  = (state_reg == S_POP);

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = start ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = stat.pop_needed ? S_POP : S_IDLE;
            S_POP:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/scba_dpath.sv */
// Datapath with size classing, stack counts, bump pointer and the free-stack memory.
module scba_dpath
    import scba_pkg::*;
#(
    parameter int STACK_DEPTH  = 256,
    parameter int CLASS_COUNT  = 8,
    parameter int ADDRESS_BITS = 40
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    input  req_t               req,
    input  logic [FIELD_W-1:0] arena_base,
    input  logic [BYTES_W-1:0] arena_bytes,
    output dp_stat_t           stat,
    output logic               done,
    output result_t            result
);

    localparam int CW        = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int MEM_DEPTH = CLASS_COUNT * STACK_DEPTH;
    localparam int MA_W      = $clog2(MEM_DEPTH);
    localparam int STORE_W   = (ADDRESS_BITS < FIELD_W) ? ADDRESS_BITS : FIELD_W;
    localparam logic [FIELD_W-1:0] ADDR_MASK = (ADDRESS_BITS >= FIELD_W) ? {FIELD_W{1'b1}} :
        ((FIELD_W'(1) << ADDRESS_BITS) - FIELD_W'(1));
    localparam int SUM_W = BYTES_W + 1;

    // Smallest class c with (16 << c) >= size; a 16-bit size never needs more than 12.
    function automatic logic [RAW_CLASS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
        logic [RAW_CLASS_W-1:0] r;
        r = RAW_CLASS_W'(12);
        for (int c = 12; c >= 0; c--)
        begin
            if ((32'd16 << c) >= 32'(size))
            begin
                r = RAW_CLASS_W'(c);
            end
        end
        return r;
    endfunction

    logic                   kind_reg;
    logic                   too_big_reg;
    logic [RAW_CLASS_W-1:0] cls_reg;
    logic [FIELD_W-1:0]     faddr_reg;
    logic [CNT_W-1:0]       count_reg [CLASS_COUNT];
    logic [BYTES_W-1:0]     bump_reg;
    logic                   done_reg;
    result_t                result_reg;
    logic [STORE_W-1:0]     mem [MEM_DEPTH];
    logic [STORE_W-1:0]     mem_rdata_reg;

    logic [RAW_CLASS_W-1:0] raw_class;
    logic [CW-1:0]          cls;
    logic [CNT_W-1:0]       cnt;
    logic                   empty;
    logic                   full;
    logic [SUM_W-1:0]       blk;
    logic [SUM_W-1:0]       bump_end;
    logic                   fits;
    logic [FIELD_W-1:0]     bump_addr;
    logic [MA_W-1:0]        mem_addr;
    logic                   mem_we;
    logic                   mem_re;

    assign raw_class = class_of(req.req_size);
    assign cls       = cls_reg[CW-1:0];
    assign cnt       = count_reg[cls];
    assign empty     = (cnt == '0);
    assign full      = (cnt == CNT_W'(STACK_DEPTH));
    assign blk       = SUM_W'(16) << cls_reg;
    assign bump_end  = SUM_W'(bump_reg) + blk;
    assign fits      = (bump_end <= SUM_W'(arena_bytes));
    assign bump_addr = (arena_base + FIELD_W'(bump_reg)) & ADDR_MASK;

    assign stat.pop_needed = !too_big_reg && (kind_reg == KIND_ALLOC) && !empty;

    // A pop reads the top entry below the count, a push writes at the count.
    assign mem_addr = MA_W'(cls) * MA_W'(STACK_DEPTH)
                    + MA_W'(stat.pop_needed ? (cnt - CNT_W'(1)) : cnt);
    assign mem_we   = cmd.exec && !too_big_reg && (kind_reg == KIND_FREE) && !full;
    assign mem_re   = cmd.exec && stat.pop_needed;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= STORE_W'(faddr_reg);
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= req.kind;
            cls_reg     <= raw_class;
            too_big_reg <= (32'(raw_class) >= 32'(CLASS_COUNT));
            faddr_reg   <= req.free_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                count_reg[i] <= '0;
            end
            bump_reg <= '0;
        end
        else if (cmd.exec && !too_big_reg)
        begin
            if (kind_reg == KIND_ALLOC)
            begin
                if (!empty)
                begin
                    count_reg[cls] <= cnt - CNT_W'(1);
                end
                else if (fits)
                begin
                    bump_reg <= bump_end[BYTES_W-1:0];
                end
            end
            else if (!full)
            begin
                count_reg[cls] <= cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.exec && !stat.pop_needed) || cmd.pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            result_reg.block_addr <= FIELD_W'(mem_rdata_reg);
            result_reg.status     <= ST_OK;
            result_reg.size_class <= cls_reg[CLASS_W-1:0];
        end
        else if (cmd.exec)
        begin
            result_reg.block_addr <= '0;
            result_reg.size_class <= cls_reg[CLASS_W-1:0];
            if (too_big_reg)
            begin
                result_reg.status     <= ST_TOO_LARGE;
                result_reg.size_class <= '0;
            end
            else if (kind_reg == KIND_ALLOC)
            begin
                if (fits)
                begin
                    result_reg.status     <= ST_OK;
                    result_reg.block_addr <= bump_addr;
                end
                else
                begin
                    result_reg.status <= ST_NO_MEMORY;
                end
            end
            else
            begin
                result_reg.status <= full ? ST_FULL : ST_OK;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A failed or rejected transaction never reports an address.
    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (result_reg.status != ST_OK) |-> (result_reg.block_addr == '0))
        else $error("failed transaction reports a nonzero address");

    // The cycle after a stack pop always delivers a successful result.
    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> done_reg && (result_reg.status == ST_OK))
        else $error("stack pop did not deliver a successful result");

    // A push to a full class stack is reported as such.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && !too_big_reg && (kind_reg == KIND_FREE) && full
        |=> done_reg && (result_reg.status == ST_FULL))
        else $error("push to a full stack not reported");

endmodule
